// ===== src/pit3_pkg.sv =====
`default_nettype none
package pit3_pkg;

   localparam int CHANNELS = 3;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_GATE  = 2'd3
   } op_type;

   localparam logic [1:0] ADDR_CONTROL = 2'd3;

   localparam logic [1:0] ORDER_LATCH     = 2'd0;
   localparam logic [1:0] ORDER_HIGH_ONLY = 2'd2;
   localparam logic [1:0] ORDER_LOW_HIGH  = 2'd3;

   localparam logic [1:0] DRV_LOW    = 2'd0;
   localparam logic [1:0] DRV_HIGH   = 2'd1;
   localparam logic [1:0] DRV_TOGGLE = 2'd2;
   localparam logic [1:0] DRV_KEEP   = 2'd3;

   localparam logic [3:0] ROW_MODE_OUT   = 4'd0;
   localparam logic [3:0] ROW_DOUBLE     = 4'd1;
   localparam logic [3:0] ROW_AUTOSTART  = 4'd2;
   localparam logic [3:0] ROW_START_OUT  = 4'd3;
   localparam logic [3:0] ROW_END_OUT    = 4'd4;
   localparam logic [3:0] ROW_RESTART    = 4'd5;
   localparam logic [3:0] ROW_GLOW_OUT   = 4'd6;
   localparam logic [3:0] ROW_GLOW_STOP  = 4'd7;
   localparam logic [3:0] ROW_GRISE_OUT  = 4'd8;
   localparam logic [3:0] ROW_GRISE_LOAD = 4'd9;

   localparam logic [1:0] MODE_TABLE [10][8] = '{
      '{2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
      '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1},
      '{2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1},
      '{2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2},
      '{2'd1, 2'd1, 2'd0, 2'd3, 2'd0, 2'd0, 2'd0, 2'd3},
      '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1},
      '{2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1},
      '{2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1},
      '{2'd3, 2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
      '{2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1}
   };

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] address;
      logic [7:0] write_data;
      logic [7:0] tick_count;
      logic [2:0] gate_levels;
   } item_type;

   function automatic logic [1:0] mode_tbl(input logic [3:0] row, input logic [2:0] mode);
      return MODE_TABLE[row][mode];
   endfunction

   function automatic logic drive_out(input logic [1:0] how, input logic cur);
      logic res;
      case (how)
         DRV_LOW:    res = 1'b0;
         DRV_HIGH:   res = 1'b1;
         DRV_TOGGLE: res = ~cur;
         default:    res = cur;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== src/pit3_if.sv =====
`default_nettype none
interface pit3_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [1:0] address;
   logic [7:0] write_data;
   logic [7:0] tick_count;
   logic [2:0] gate_levels;

   modport source (output valid, op, address, write_data, tick_count, gate_levels,
                   input ready);
   modport sink   (input valid, op, address, write_data, tick_count, gate_levels,
                   output ready);
endinterface

interface pit3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [2:0] out_levels;

   modport source (output valid, read_data, out_levels, input ready);
   modport sink   (input valid, read_data, out_levels, output ready);
endinterface
`default_nettype wire

// ===== src/pit3_channel.sv =====
`default_nettype none
module pit3_channel (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          chan_id,
   input  wire logic                step,
   input  wire pit3_pkg::item_type  item,
   output logic [7:0]               rd_byte,
   output logic                     out_next
);
   import pit3_pkg::*;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  order;
      logic        bptr;
      logic        counting;
      logic        loaded;
      logic        pending;
      logic [15:0] start;
      logic [15:0] count;
      logic [15:0] latched;
      logic        gate;
      logic        out;
   } chan_state_type;

   localparam chan_state_type STATE_RESET = '{
      mode: 3'd0, order: 2'd0, bptr: 1'b0, counting: 1'b0, loaded: 1'b0,
      pending: 1'b0, start: 16'd0, count: 16'd0, latched: 16'd0,
      gate: 1'b1, out: 1'b0
   };

   chan_state_type state_ff, state_in;
   logic [8:0]     dec;
   logic           g1;

   always_comb begin
      state_in = state_ff;
      rd_byte  = 8'd0;
      dec      = 9'd0;
      g1       = item.gate_levels[chan_id];
      case (item.op)
         OP_WRITE: begin
            if (item.address == ADDR_CONTROL) begin
               if (item.write_data[7:6] == chan_id) begin
                  if (item.write_data[5:4] != ORDER_LATCH) begin
                     state_in.order    = item.write_data[5:4];
                     state_in.mode     = item.write_data[3:1];
                     state_in.loaded   = 1'b0;
                     state_in.bptr     = (item.write_data[5:4] == ORDER_HIGH_ONLY);
                     state_in.counting = 1'b0;
                     state_in.out      =
                        (mode_tbl(ROW_MODE_OUT, item.write_data[3:1]) == DRV_HIGH);
                  end else begin
                     state_in.latched = state_ff.count;
                     state_in.bptr    = 1'b0;
                  end
               end
            end else if (item.address == chan_id) begin
               if (state_ff.bptr) state_in.start[15:8] = item.write_data;
               else               state_in.start[7:0]  = item.write_data;
               state_in.bptr = ~state_ff.bptr;
               if (state_ff.order != ORDER_LOW_HIGH || state_ff.bptr) begin
                  state_in.loaded = 1'b1;
                  if (mode_tbl(ROW_AUTOSTART, state_ff.mode) != 2'd0)
                     state_in.pending = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (item.address == chan_id) begin
               rd_byte       = state_ff.bptr ? state_ff.latched[15:8] : state_ff.latched[7:0];
               state_in.bptr = ~state_ff.bptr;
            end
         end
         OP_TICK: begin
            if (state_ff.loaded) begin
               if (state_ff.pending) begin
                  state_in.out     = drive_out(mode_tbl(ROW_START_OUT, state_ff.mode),
                                               state_ff.out);
                  state_in.count   = state_ff.start;
                  state_in.pending = 1'b0;
                  if (state_ff.gate) state_in.counting = 1'b1;
               end
               if (state_in.counting) begin
                  dec = (mode_tbl(ROW_DOUBLE, state_ff.mode) == 2'd1) ?
                        {item.tick_count, 1'b0} : {1'b0, item.tick_count};
                  if (state_in.count > {7'd0, dec} || state_in.count == 16'd0) begin
                     state_in.count = state_in.count - {7'd0, dec};
                  end else begin
                     state_in.out      = drive_out(mode_tbl(ROW_END_OUT, state_ff.mode),
                                                   state_in.out);
                     state_in.counting = 1'b0;
                     if (mode_tbl(ROW_RESTART, state_ff.mode) == 2'd1)
                        state_in.pending = 1'b1;
                  end
               end
            end
         end
         default: begin
            if (state_ff.gate != g1) begin
               if (!g1) begin
                  state_in.out = drive_out(mode_tbl(ROW_GLOW_OUT, state_ff.mode), state_ff.out);
                  if (mode_tbl(ROW_GLOW_STOP, state_ff.mode) == 2'd1)
                     state_in.counting = 1'b0;
               end else begin
                  state_in.counting = 1'b1;
                  state_in.out = drive_out(mode_tbl(ROW_GRISE_OUT, state_ff.mode),
                                           state_ff.out);
                  if (mode_tbl(ROW_GRISE_LOAD, state_ff.mode) == 2'd1)
                     state_in.count = state_ff.start;
               end
            end
            state_in.gate = g1;
         end
      endcase
   end

   assign out_next = state_in.out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/programmable_interval_timer_3ch.sv =====
// channel  role    payload
// req_bus  sink    op, address, write_data, tick_count, gate_levels
// rsp_bus  source  read_data, out_levels
//
// One word per cycle while the result side is not stalled; each word gives one result,
// which passes the input register, then the per-channel update into the result register.
// Synchronous reset: all channels cleared, gates high, OUT low.
// A stalled result holds the update stage; the input register takes a word while
// the result waits only if the input register is empty.
`default_nettype none
module programmable_interval_timer_3ch (
   input  wire logic clock,
   input  wire logic reset,
   pit3_req_if.sink  req_bus,
   pit3_rsp_if.source rsp_bus
);
   import pit3_pkg::*;

   item_type   item_ff, item_in;
   logic       in_valid_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic [2:0] rsp_out_levels_ff, rsp_out_levels_in;
   logic       advance;
   logic       take;
   logic [7:0] rd_vec  [CHANNELS];
   logic       out_vec [CHANNELS];

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;

   assign item_in = '{op: req_bus.op, address: req_bus.address,
                      write_data: req_bus.write_data, tick_count: req_bus.tick_count,
                      gate_levels: req_bus.gate_levels};

   for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_chan
      pit3_channel u_chan (
         .clock    (clock),
         .reset    (reset),
         .chan_id  (2'(gi)),
         .step     (advance),
         .item     (item_ff),
         .rd_byte  (rd_vec[gi]),
         .out_next (out_vec[gi])
      );
   end

   always_comb begin
      rsp_read_data_in  = 8'd0;
      rsp_out_levels_in = 3'd0;
      for (int i = 0; i < CHANNELS; i++) begin
         rsp_read_data_in     = rsp_read_data_in | rd_vec[i];
         rsp_out_levels_in[i] = out_vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take)         in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance)            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
      if (take) item_ff <= item_in;
      if (advance) begin
         rsp_read_data_ff  <= rsp_read_data_in;
         rsp_out_levels_ff <= rsp_out_levels_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_data  = rsp_read_data_ff;
   assign rsp_bus.out_levels = rsp_out_levels_ff;

endmodule
`default_nettype wire

// ===== sim/programmable_interval_timer_3ch_test.sv =====
import pit3_pkg::*;

typedef struct packed {
   logic [7:0] read_data;
   logic [2:0] out_levels;
} pin_result_type;

class pit_scoreboard;
   logic [2:0]  mode      [CHANNELS];
   logic [1:0]  order     [CHANNELS];
   logic        pointer   [CHANNELS];
   logic        counting  [CHANNELS];
   logic        loaded    [CHANNELS];
   logic        armed     [CHANNELS];
   logic [15:0] start_val [CHANNELS];
   logic [15:0] count_val [CHANNELS];
   logic [15:0] latch_val [CHANNELS];
   logic [2:0]  gates;
   logic [2:0]  pins;
   pin_result_type due_pins [$];
   int          fail_count;

   function new();
      for (int ch = 0; ch < CHANNELS; ch++) begin
         mode[ch]      = '0;
         order[ch]     = '0;
         pointer[ch]   = 1'b0;
         counting[ch]  = 1'b0;
         loaded[ch]    = 1'b0;
         armed[ch]     = 1'b0;
         start_val[ch] = '0;
         count_val[ch] = '0;
         latch_val[ch] = '0;
      end
      gates      = 3'b111;
      pins       = 3'b000;
      fail_count = 0;
   endfunction

   // per-mode behavior, entry 0 is mode 0
   function logic [1:0] behavior(logic [3:0] row, int ch);
      logic [0:7][1:0] line;
      case (row)
         ROW_MODE_OUT:   line = {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1};
         ROW_DOUBLE:     line = {2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1};
         ROW_AUTOSTART:  line = {2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1};
         ROW_START_OUT:  line = {2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2};
         ROW_END_OUT:    line = {2'd1, 2'd1, 2'd0, 2'd3, 2'd0, 2'd0, 2'd0, 2'd3};
         ROW_RESTART:    line = {2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1};
         ROW_GLOW_OUT:   line = {2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1};
         ROW_GLOW_STOP:  line = {2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1};
         ROW_GRISE_OUT:  line = {2'd3, 2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3};
         ROW_GRISE_LOAD: line = {2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1};
         default:        line = '0;
      endcase
      return line[mode[ch]];
   endfunction

   function logic flag(logic [3:0] row, int ch);
      return behavior(row, ch) != 2'd0;
   endfunction

   function void drive_pin(int ch, logic [3:0] row);
      case (behavior(row, ch))
         DRV_LOW:    pins[ch] = 1'b0;
         DRV_HIGH:   pins[ch] = 1'b1;
         DRV_TOGGLE: pins[ch] = ~pins[ch];
         default:    ;
      endcase
   endfunction

   function void tick_channel(int ch, logic [7:0] ticks);
      int step;
      int cur;
      int left;
      if (!loaded[ch]) return;
      if (armed[ch]) begin
         drive_pin(ch, ROW_START_OUT);
         count_val[ch] = start_val[ch];
         if (gates[ch]) counting[ch] = 1'b1;
         armed[ch] = 1'b0;
      end
      if (counting[ch]) begin
         step = int'(ticks);
         if (flag(ROW_DOUBLE, ch)) step = step * 2;
         cur  = int'(count_val[ch]);
         left = cur - step;
         // zero stands for 65536
         if (left > 0 || cur == 0) begin
            count_val[ch] = 16'(left);
         end else begin
            drive_pin(ch, ROW_END_OUT);
            counting[ch] = 1'b0;
            if (flag(ROW_RESTART, ch)) armed[ch] = 1'b1;
         end
      end
   endfunction

   function void note_word(item_type w);
      int ch;
      logic [7:0] rd;
      pin_result_type due;
      rd = '0;
      case (w.op)
         OP_WRITE: begin
            if (w.address == ADDR_CONTROL) begin
               ch = int'(w.write_data[7:6]);
               if (ch < CHANNELS) begin
                  if (w.write_data[5:4] != ORDER_LATCH) begin
                     order[ch]    = w.write_data[5:4];
                     mode[ch]     = w.write_data[3:1];
                     loaded[ch]   = 1'b0;
                     pointer[ch]  = (order[ch] == ORDER_HIGH_ONLY);
                     counting[ch] = 1'b0;
                     pins[ch]     = flag(ROW_MODE_OUT, ch);
                  end else begin
                     latch_val[ch] = count_val[ch];
                     pointer[ch]   = 1'b0;
                  end
               end
            end else if (int'(w.address) < CHANNELS) begin
               ch = int'(w.address);
               if (pointer[ch]) start_val[ch][15:8] = w.write_data;
               else start_val[ch][7:0] = w.write_data;
               pointer[ch] = ~pointer[ch];
               if (order[ch] != ORDER_LOW_HIGH || !pointer[ch]) begin
                  loaded[ch] = 1'b1;
                  if (flag(ROW_AUTOSTART, ch)) armed[ch] = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (int'(w.address) < CHANNELS) begin
               ch = int'(w.address);
               rd = pointer[ch] ? latch_val[ch][15:8] : latch_val[ch][7:0];
               pointer[ch] = ~pointer[ch];
            end
         end
         OP_TICK: begin
            for (int c = 0; c < CHANNELS; c++) tick_channel(c, w.tick_count);
         end
         default: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (gates[c] != w.gate_levels[c]) begin
                  if (!w.gate_levels[c]) begin
                     drive_pin(c, ROW_GLOW_OUT);
                     if (flag(ROW_GLOW_STOP, c)) counting[c] = 1'b0;
                  end else begin
                     counting[c] = 1'b1;
                     drive_pin(c, ROW_GRISE_OUT);
                     if (flag(ROW_GRISE_LOAD, c)) count_val[c] = start_val[c];
                  end
               end
            end
            gates = w.gate_levels;
         end
      endcase
      due.read_data  = rd;
      due.out_levels = pins;
      due_pins.push_back(due);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task check_result(logic [7:0] rd, logic [2:0] outs);
      pin_result_type want;
      if (due_pins.size() == 0) begin
         report($sformatf("result word with none due: read_data %02h out_levels %03b",
                          rd, outs));
         return;
      end
      want = due_pins.pop_front();
      if (rd !== want.read_data)
         report($sformatf("read_data %02h, due %02h", rd, want.read_data));
      if (outs !== want.out_levels)
         report($sformatf("out_levels %03b, due %03b", outs, want.out_levels));
   endtask

   function int pending();
      return due_pins.size();
   endfunction
endclass

module programmable_interval_timer_3ch_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pit3_req_if req_bus ();
   pit3_rsp_if rsp_bus ();

   pit_scoreboard book;

   int idle_pct     = 0;
   int stall_pct    = 0;
   bit hold_request = 1'b0;
   int words_sent   = 0;

   always #2ns clock = ~clock;

   programmable_interval_timer_3ch i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] load_byte();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 8'($urandom_range(15));
      if (r < 70) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] tick_amount();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 8'd0;
      if (r < 55) return 8'($urandom_range(4, 1));
      if (r < 85) return 8'($urandom_range(40, 5));
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [2:0] gate_pattern();
      return ($urandom_range(99) < 60) ? 3'b111 : 3'($urandom);
   endfunction

   task automatic send_item(input op_type op, input logic [1:0] addr, input logic [7:0] data,
                            input logic [7:0] ticks, input logic [2:0] gate_set);
      item_type w;
      w = '{op: op, address: addr, write_data: data, tick_count: ticks, gate_levels: gate_set};
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= w.op;
      req_bus.address     <= w.address;
      req_bus.write_data  <= w.write_data;
      req_bus.tick_count  <= w.tick_count;
      req_bus.gate_levels <= w.gate_levels;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      book.note_word(w);
      words_sent++;
   endtask

   task automatic random_burst(input int words);
      int target;
      int kind;
      int ch;
      int order;
      target = words_sent + words;
      while (words_sent < target) begin
         kind = $urandom_range(99);
         ch   = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
         if (kind < 60) begin
            // program a channel, load it, then let it run
            order = $urandom_range(3, 1);
            send_item(OP_WRITE, ADDR_CONTROL,
                      {2'(ch), 2'(order), 3'($urandom), 1'($urandom)},
                      any_byte(), 3'($urandom));
            if (ch == 3) ch = $urandom_range(2);
            repeat ((order == ORDER_LOW_HIGH) ? 2 : 1)
               send_item(OP_WRITE, 2'(ch), load_byte(), any_byte(), 3'($urandom));
            repeat ($urandom_range(12, 3)) begin
               kind = $urandom_range(99);
               if (kind < 70)
                  send_item(OP_TICK, 2'($urandom), any_byte(), tick_amount(), 3'($urandom));
               else if (kind < 85)
                  send_item(OP_GATE, 2'($urandom), any_byte(), any_byte(), gate_pattern());
               else if (kind < 93)
                  send_item(OP_READ, 2'(ch), any_byte(), any_byte(), 3'($urandom));
               else
                  send_item(OP_WRITE, 2'(ch), load_byte(), any_byte(), 3'($urandom));
            end
         end else if (kind < 75) begin
            send_item(OP_WRITE, ADDR_CONTROL, {2'(ch), ORDER_LATCH, 4'($urandom)},
                      any_byte(), 3'($urandom));
            repeat (2) send_item(OP_READ, 2'(ch), any_byte(), any_byte(), 3'($urandom));
         end else begin
            send_item(op_type'($urandom_range(3)), 2'($urandom), any_byte(), any_byte(),
                      3'($urandom));
         end
      end
   endtask

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            book.check_result(rsp_bus.read_data, rsp_bus.out_levels);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
         else quiet++;
      end
      $display("programmable_interval_timer_3ch regression: fail");
      $finish;
   end

   initial begin : stimulus
      book = new();
      req_bus.valid       <= 1'b0;
      req_bus.op          <= OP_WRITE;
      req_bus.address     <= 2'd0;
      req_bus.write_data  <= 8'd0;
      req_bus.tick_count  <= 8'd0;
      req_bus.gate_levels <= 3'b111;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_READ, 2'd0, any_byte(), any_byte(), 3'($urandom));
      send_item(OP_WRITE, ADDR_CONTROL, 8'hF6, any_byte(), 3'($urandom));  // channel 3
      send_item(OP_WRITE, ADDR_CONTROL, 8'h36, any_byte(), 3'($urandom));
      send_item(OP_WRITE, 2'd0, 8'h04, any_byte(), 3'($urandom));
      send_item(OP_WRITE, 2'd0, 8'h00, any_byte(), 3'($urandom));
      send_item(OP_TICK, 2'($urandom), any_byte(), 8'd1, 3'($urandom));
      send_item(OP_TICK, 2'($urandom), any_byte(), 8'd0, 3'($urandom));
      send_item(OP_TICK, 2'($urandom), any_byte(), 8'd255, 3'($urandom));
      send_item(OP_WRITE, ADDR_CONTROL, 8'h50, any_byte(), 3'($urandom));
      send_item(OP_WRITE, 2'd1, 8'h00, any_byte(), 3'($urandom));          // count of zero
      send_item(OP_TICK, 2'($urandom), any_byte(), 8'd255, 3'($urandom));
      send_item(OP_WRITE, ADDR_CONTROL, 8'h40, any_byte(), 3'($urandom));  // latch
      send_item(OP_READ, 2'd1, any_byte(), any_byte(), 3'($urandom));
      send_item(OP_READ, 2'd1, any_byte(), any_byte(), 3'($urandom));
      send_item(OP_WRITE, ADDR_CONTROL, 8'hA2, any_byte(), 3'($urandom));
      send_item(OP_WRITE, 2'd2, 8'hFF, any_byte(), 3'($urandom));
      send_item(OP_GATE, 2'($urandom), any_byte(), any_byte(), 3'b000);
      send_item(OP_GATE, 2'($urandom), any_byte(), any_byte(), 3'b111);
      send_item(OP_TICK, 2'($urandom), any_byte(), 8'h80, 3'($urandom));
      send_item(OP_READ, ADDR_CONTROL, any_byte(), any_byte(), 3'($urandom));
      send_item(OP_WRITE, ADDR_CONTROL, 8'hBB, any_byte(), 3'($urandom));
      send_item(OP_GATE, 2'($urandom), any_byte(), any_byte(), 3'b011);
      send_item(OP_GATE, 2'($urandom), any_byte(), any_byte(), 3'b111);  // rise, not loaded
      send_item(OP_WRITE, ADDR_CONTROL, 8'h1F, any_byte(), 3'($urandom));
      send_item(OP_WRITE, 2'd0, 8'hFF, any_byte(), 3'($urandom));

      random_burst(300);
      idle_pct = 78;
      random_burst(250);
      idle_pct  = 0;
      stall_pct = 78;
      random_burst(250);
      idle_pct  = 28;
      stall_pct = 28;
      random_burst(250);
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 1'b1;
      random_burst(150);
      req_bus.valid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.fail_count == 0)
         $display("programmable_interval_timer_3ch regression: pass");
      else
         $display("programmable_interval_timer_3ch regression: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/pit3_pkg.sv
src/pit3_if.sv
src/pit3_channel.sv
src/programmable_interval_timer_3ch.sv
sim/programmable_interval_timer_3ch_test.sv
